FILE: rtl/lcrt_pkg.sv
package lcrt_pkg;

  localparam int RING_ENTRIES = 65536;
  localparam int RING_AW      = $clog2(RING_ENTRIES);
  localparam int BLOCK_BYTES  = 8192;
  localparam int BLK_SHIFT    = $clog2(BLOCK_BYTES);
  localparam int POS_BITS     = 48;
  localparam int FSIZE_W      = 41;
  localparam int HSIZE_W      = 16;
  localparam int BCNT_W       = 17;
  localparam int OFFS_W       = 29;
  localparam int GUARD_W      = RING_AW + 1;
  localparam int DIV_CNT_W    = $clog2(POS_BITS);
  localparam int BLKPOS_W     = POS_BITS - BLK_SHIFT;

  localparam logic [POS_BITS-1:0] FSIZE_RESET = POS_BITS'(64'd1073741824);
  localparam logic [HSIZE_W-1:0]  HSIZE_RESET = HSIZE_W'(4096);
  localparam logic [BCNT_W-1:0]   BCNT_RESET  = BCNT_W'(2048);

  localparam logic REQ_MARK  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    CFG_FILE_SIZE   = 2'd0,
    CFG_HEADER_SIZE = 2'd1,
    CFG_BLOCK_COUNT = 2'd2,
    CFG_INITIAL_POS = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK_DIV,
    S_MARK_BRIDGE,
    S_MARK_END,
    S_WALK,
    S_FLUSH_DIV,
    S_FLUSH_FIN,
    S_DONE
  } state_t;

endpackage

FILE: rtl/lcrt_ram.sv
module lcrt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/log_completion_ring_tracker.sv
// Mark: if the ring is full the result comes without a ring write; if file_size is zero
// only the ring write is done; else a 48-step remainder against file_size, then the ring
// write, preceded by a bridging write when the remainder equals header_size.
// Flush: walks the chain links (one ring read per cycle), then runs the 48-step block
// division when a range is returned. One request in flight at a time; the result
// register frees the input side. Reset: a clearing pass zeroes the 65536-entry ring.
module log_completion_ring_tracker
  import lcrt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [POS_BITS-1:0] in_start_pos,
  input  logic [POS_BITS-1:0] in_end_pos,

  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_accepted,
  output logic                out_flush_valid,
  output logic [POS_BITS-1:0] out_flush_start,
  output logic [POS_BITS-1:0] out_flush_end,
  output logic                out_reach_tail,
  output logic [OFFS_W-1:0]   out_buffer_offset,
  output logic [POS_BITS-1:0] out_contiguous_pos,

  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [POS_BITS-1:0] cfg_wdata
);

  state_t state_r, state_nxt;

  logic [FSIZE_W-1:0]  fsize_r, fsize_nxt;
  logic [HSIZE_W-1:0]  hsize_r, hsize_nxt;
  logic [BCNT_W-1:0]   bcnt_r, bcnt_nxt;
  logic [POS_BITS-1:0] contig_r, contig_nxt;
  logic [POS_BITS-1:0] scanned_r, scanned_nxt;

  logic [POS_BITS-1:0] start_r, start_nxt;
  logic [POS_BITS-1:0] end_r, end_nxt;
  logic [GUARD_W-1:0]  guard_r, guard_nxt;
  logic [RING_AW-1:0]  clr_cnt_r, clr_cnt_nxt;

  logic [POS_BITS-1:0]  div_q_r, div_q_nxt;
  logic [FSIZE_W-1:0]   div_rem_r, div_rem_nxt;
  logic [FSIZE_W-1:0]   div_d_r, div_d_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  logic                res_acc_r, res_acc_nxt;
  logic                res_fv_r, res_fv_nxt;
  logic [POS_BITS-1:0] res_fs_r, res_fs_nxt;
  logic [POS_BITS-1:0] res_fe_r, res_fe_nxt;
  logic                res_tail_r, res_tail_nxt;
  logic [OFFS_W-1:0]   res_off_r, res_off_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_acc_r, out_fv_r, out_tail_r;
  logic [POS_BITS-1:0] out_fs_r, out_fe_r, out_cp_r;
  logic [OFFS_W-1:0]   out_off_r;
  logic                out_load;

  logic                ram_we;
  logic [RING_AW-1:0]  ram_waddr, ram_raddr;
  logic [POS_BITS-1:0] ram_wdata, ram_rdata;

  lcrt_ram #(.WIDTH(POS_BITS), .DEPTH(RING_ENTRIES)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // restoring divider step, one quotient bit per cycle
  logic [FSIZE_W:0]   div_shift, div_diff;
  logic               div_ge;
  logic [FSIZE_W-1:0] div_rem_step;
  logic [POS_BITS-1:0] div_q_step;

  assign div_shift    = {div_rem_r, div_q_r[POS_BITS-1]};
  assign div_ge       = div_shift >= {1'b0, div_d_r};
  assign div_diff     = div_shift - {1'b0, div_d_r};
  assign div_rem_step = div_ge ? div_diff[FSIZE_W-1:0] : div_shift[FSIZE_W-1:0];
  assign div_q_step   = {div_q_r[POS_BITS-2:0], div_ge};

  logic [BCNT_W-1:0]   bc_eff;
  logic [BLKPOS_W:0]   buf_end_blk;
  logic [POS_BITS:0]   buf_end;
  logic                fin_tail;
  logic [OFFS_W:0]     fin_off;
  logic                ring_full;

  assign bc_eff      = (bcnt_r == '0) ? BCNT_W'(1) : bcnt_r;
  // (scanned/bufsize + 1) * bufsize in blocks: hi - (hi mod bc) + bc
  assign buf_end_blk = {1'b0, scanned_r[POS_BITS-1:BLK_SHIFT]}
                     - (BLKPOS_W+1)'(div_rem_r[BCNT_W-1:0])
                     + (BLKPOS_W+1)'(bc_eff);
  assign buf_end     = {buf_end_blk, {BLK_SHIFT{1'b0}}};
  assign fin_tail    = {1'b0, contig_r} >= buf_end;
  assign fin_off     = {div_rem_r[BCNT_W-1:0], scanned_r[BLK_SHIFT-1:0]};
  assign ring_full   = ({1'b0, contig_r} + (POS_BITS+1)'(RING_ENTRIES))
                       <= {1'b0, in_start_pos};

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    fsize_nxt    = fsize_r;
    hsize_nxt    = hsize_r;
    bcnt_nxt     = bcnt_r;
    contig_nxt   = contig_r;
    scanned_nxt  = scanned_r;
    start_nxt    = start_r;
    end_nxt      = end_r;
    guard_nxt    = guard_r;
    clr_cnt_nxt  = clr_cnt_r;
    div_q_nxt    = div_q_r;
    div_rem_nxt  = div_rem_r;
    div_d_nxt    = div_d_r;
    div_cnt_nxt  = div_cnt_r;
    res_acc_nxt  = res_acc_r;
    res_fv_nxt   = res_fv_r;
    res_fs_nxt   = res_fs_r;
    res_fe_nxt   = res_fe_r;
    res_tail_nxt = res_tail_r;
    res_off_nxt  = res_off_r;
    out_load     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = start_r[RING_AW-1:0];
    ram_wdata    = end_r;
    ram_raddr    = contig_r[RING_AW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {RING_AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          start_nxt    = in_start_pos;
          end_nxt      = in_end_pos;
          res_acc_nxt  = 1'b1;
          res_fv_nxt   = 1'b0;
          res_fs_nxt   = '0;
          res_fe_nxt   = '0;
          res_tail_nxt = 1'b0;
          res_off_nxt  = '0;
          guard_nxt    = '0;
          if (in_req_type == REQ_FLUSH) begin
            state_nxt = S_WALK;
          end else if (ring_full) begin
            res_acc_nxt = 1'b0;
            state_nxt   = S_DONE;
          end else if (fsize_r != '0) begin
            div_q_nxt   = in_start_pos;
            div_rem_nxt = '0;
            div_d_nxt   = fsize_r;
            div_cnt_nxt = '0;
            state_nxt   = S_MARK_DIV;
          end else begin
            state_nxt = S_MARK_END;
          end
        end
      end
      S_MARK_DIV: begin
        div_q_nxt   = div_q_step;
        div_rem_nxt = div_rem_step;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(POS_BITS - 1)) begin
          state_nxt = (div_rem_step == FSIZE_W'(hsize_r)) ? S_MARK_BRIDGE : S_MARK_END;
        end
      end
      S_MARK_BRIDGE: begin
        ram_we    = 1'b1;
        ram_waddr = start_r[RING_AW-1:0] - RING_AW'(hsize_r);
        ram_wdata = start_r;
        state_nxt = S_MARK_END;
      end
      S_MARK_END: begin
        ram_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_WALK: begin
        // ram_rdata holds the entry at slot(contig_r)
        if (ram_rdata > contig_r && guard_r <= GUARD_W'(RING_ENTRIES)) begin
          contig_nxt = ram_rdata;
          guard_nxt  = guard_r + 1'b1;
          ram_raddr  = ram_rdata[RING_AW-1:0];
        end else if (contig_r > scanned_r) begin
          div_q_nxt   = POS_BITS'(scanned_r[POS_BITS-1:BLK_SHIFT]);
          div_rem_nxt = '0;
          div_d_nxt   = FSIZE_W'(bc_eff);
          div_cnt_nxt = '0;
          state_nxt   = S_FLUSH_DIV;
        end else begin
          res_fs_nxt = scanned_r;
          res_fe_nxt = scanned_r;
          state_nxt  = S_DONE;
        end
      end
      S_FLUSH_DIV: begin
        div_q_nxt   = div_q_step;
        div_rem_nxt = div_rem_step;
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(POS_BITS - 1)) begin
          state_nxt = S_FLUSH_FIN;
        end
      end
      S_FLUSH_FIN: begin
        res_fv_nxt   = 1'b1;
        res_fs_nxt   = scanned_r;
        res_fe_nxt   = fin_tail ? buf_end[POS_BITS-1:0] : contig_r;
        res_tail_nxt = fin_tail;
        res_off_nxt  = fin_off[OFFS_W-1:0];
        scanned_nxt  = fin_tail ? buf_end[POS_BITS-1:0] : contig_r;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FILE_SIZE:   fsize_nxt = cfg_wdata[FSIZE_W-1:0];
        CFG_HEADER_SIZE: hsize_nxt = cfg_wdata[HSIZE_W-1:0];
        CFG_BLOCK_COUNT: bcnt_nxt  = cfg_wdata[BCNT_W-1:0];
        CFG_INITIAL_POS: begin
          contig_nxt  = cfg_wdata;
          scanned_nxt = cfg_wdata;
        end
        default: ;
      endcase
    end

    out_valid_nxt = (out_valid_r && !out_ready) || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      fsize_r     <= FSIZE_RESET[FSIZE_W-1:0];
      hsize_r     <= HSIZE_RESET;
      bcnt_r      <= BCNT_RESET;
      contig_r    <= '0;
      scanned_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      fsize_r     <= fsize_nxt;
      hsize_r     <= hsize_nxt;
      bcnt_r      <= bcnt_nxt;
      contig_r    <= contig_nxt;
      scanned_r   <= scanned_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r    <= start_nxt;
    end_r      <= end_nxt;
    guard_r    <= guard_nxt;
    div_q_r    <= div_q_nxt;
    div_rem_r  <= div_rem_nxt;
    div_d_r    <= div_d_nxt;
    div_cnt_r  <= div_cnt_nxt;
    res_acc_r  <= res_acc_nxt;
    res_fv_r   <= res_fv_nxt;
    res_fs_r   <= res_fs_nxt;
    res_fe_r   <= res_fe_nxt;
    res_tail_r <= res_tail_nxt;
    res_off_r  <= res_off_nxt;
    if (out_load) begin
      out_acc_r  <= res_acc_r;
      out_fv_r   <= res_fv_r;
      out_fs_r   <= res_fs_r;
      out_fe_r   <= res_fe_r;
      out_tail_r <= res_tail_r;
      out_off_r  <= res_off_r;
      out_cp_r   <= contig_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_accepted       = out_acc_r;
  assign out_flush_valid    = out_fv_r;
  assign out_flush_start    = out_fs_r;
  assign out_flush_end      = out_fe_r;
  assign out_reach_tail     = out_tail_r;
  assign out_buffer_offset  = out_off_r;
  assign out_contiguous_pos = out_cp_r;

endmodule
